[src/tpel_pkg.sv]
package tpel_pkg;

  // Fixed number formats
  localparam int DLY_W    = 48;   // delay and inter-section word
  localparam int COEF_W   = 32;   // Q2.30 coefficients, Q5.26 gains
  localparam int PROD_W   = 57;   // 32 x 25 signed product
  localparam int ACC_W    = 60;   // accumulator before saturation
  localparam int PHASES   = 3;
  localparam int SLOT_CYC = 12;   // cycles one cell spends on one phase
  localparam int CYC_W    = 4;
  localparam int SLOT_W   = 4;    // enough for PHASES + 8 - 1 slots

  // Defaults for the top-level parameters
  localparam int STAGES_DEF      = 3;
  localparam int SAMPLE_BITS_DEF = 16;

  // Opcodes carried on in_tuser
  localparam logic [1:0] OP_STEP  = 2'd0;
  localparam logic [1:0] OP_PRIME = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // Sequencer broadcast to every cell
  typedef struct packed {
    logic              run;
    logic              prime;
    logic              clr;
    logic [CYC_W-1:0]  cyc;
    logic [SLOT_W-1:0] slot;
  } ctrl_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] gain;  // DC gain, Q5.26
  } sec_t;

  // Section coefficients; sections past the third pass data through
  function automatic sec_t sec_coef(input int idx);
    sec_t c;
    case (idx)
      0: begin
        c.b0 = 32'sd106119;
        c.b1 = -32'sd207758;
        c.b2 = 32'sd106119;
        c.a1 = -32'sd2119697587;
        c.a2 = 32'sd1046202214;
        c.gain = 32'sd1219909;
      end
      1: begin
        c.b0 = 32'sd1073741824;
        c.b1 = -32'sd2141053013;
        c.b2 = 32'sd1073741824;
        c.a1 = -32'sd2128612043;
        c.a2 = 32'sd1055407110;
        c.gain = 32'sd803799299;
      end
      2: begin
        c.b0 = 32'sd1073741824;
        c.b1 = -32'sd2143869499;
        c.b2 = 32'sd1073741824;
        c.a1 = -32'sd2140558555;
        c.a2 = 32'sd1067608177;
        c.gain = 32'sd306453547;
      end
      default: begin
        c.b0 = 32'sd1073741824;
        c.b1 = 32'sd0;
        c.b2 = 32'sd0;
        c.a1 = 32'sd0;
        c.a2 = 32'sd0;
        c.gain = 32'sd67108864;
      end
    endcase
    return c;
  endfunction

  // Saturate an accumulator to the 48-bit delay range
  function automatic logic signed [DLY_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-DLY_W+1){1'b0}}, {(DLY_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return {1'b0, {(DLY_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(DLY_W-1){1'b0}}};
    end else begin
      return v[DLY_W-1:0];
    end
  endfunction

endpackage

[src/tpel_cell.sv]
module tpel_cell
  import tpel_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_t                   ctrl,
  input  logic signed [DLY_W-1:0] x_in,
  output logic signed [DLY_W-1:0] y_out
);

  localparam sec_t COEF = sec_coef(IDX);

  logic                     act_r;
  logic [1:0]               ph_r;
  logic signed [DLY_W-1:0]  x_r;
  logic signed [DLY_W-1:0]  y_r;
  logic signed [PROD_W-1:0] plo_r;
  logic signed [PROD_W-1:0] s_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DLY_W-1:0]  d1_r [PHASES];
  logic signed [DLY_W-1:0]  d2_r [PHASES];

  // Which phase reaches this cell in the current slot
  logic signed [5:0] rel;
  logic              active;
  assign rel    = $signed({2'b00, ctrl.slot}) - 6'(IDX);
  assign active = (rel >= 6'sd0) && (rel < 6'(PHASES));

  // Micro-step decode: mul step m on cycles 1..10, finalize step j on odd 3..11
  logic [CYC_W-1:0] mc;
  logic [CYC_W-1:0] jc;
  logic [2:0]       m;
  logic [2:0]       j;
  logic             lo_cyc;
  logic             hi_cyc;
  logic             fin_cyc;
  assign mc      = ctrl.cyc - 4'd1;
  assign jc      = ctrl.cyc - 4'd3;
  assign m       = mc[3:1];
  assign j       = jc[3:1];
  assign lo_cyc  = ctrl.cyc[0] && (ctrl.cyc <= 4'd9);
  assign hi_cyc  = !ctrl.cyc[0] && (ctrl.cyc >= 4'd2) && (ctrl.cyc <= 4'd10);
  assign fin_cyc = ctrl.cyc[0] && (ctrl.cyc >= 4'd3);

  // Coefficient and operand for the current micro-step
  logic signed [COEF_W-1:0] coef;
  logic signed [DLY_W-1:0]  opnd;
  always_comb begin
    case (m)
      3'd0:    coef = ctrl.prime ? COEF.gain : COEF.b0;
      3'd1:    coef = ctrl.prime ? COEF.b0 : COEF.b1;
      3'd2:    coef = ctrl.prime ? '0 : COEF.a1;
      3'd3:    coef = COEF.b2;
      3'd4:    coef = COEF.a2;
      default: coef = '0;
    endcase
    opnd = ((m == 3'd2) || (m == 3'd4)) ? y_r : x_r;
  end

  // One shared multiplier: low 24 operand bits first, then the high half
  logic signed [24:0]       mb;
  logic signed [PROD_W-1:0] prod;
  assign mb   = lo_cyc ? $signed({1'b0, opnd[23:0]}) : $signed({opnd[47], opnd[47:24]});
  assign prod = coef * mb;

  // Round the finished product and combine with its base term
  logic signed [PROD_W-1:0] rsum;
  logic signed [PROD_W-1:0] q;
  logic signed [ACC_W-1:0]  qx;
  logic signed [ACC_W-1:0]  base;
  logic                     neg;
  logic signed [ACC_W-1:0]  sum;
  always_comb begin
    if (ctrl.prime && (j == 3'd0)) begin
      rsum = s_r + 57'sd2;
      q    = rsum >>> 2;
    end else begin
      rsum = s_r + 57'sd32;
      q    = rsum >>> 6;
    end
    qx = ACC_W'(q);
    case (j)
      3'd0: begin
        base = ctrl.prime ? '0 : ACC_W'(d1_r[ph_r]);
        neg  = 1'b0;
      end
      3'd1: begin
        base = ctrl.prime ? ACC_W'(y_r) : ACC_W'(d2_r[ph_r]);
        neg  = ctrl.prime;
      end
      3'd2: begin
        base = acc_r;
        neg  = 1'b1;
      end
      3'd3: begin
        base = '0;
        neg  = 1'b0;
      end
      default: begin
        base = acc_r;
        neg  = 1'b1;
      end
    endcase
    sum = neg ? (base - qx) : (base + qx);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.cyc == 4'd0) begin
      x_r  <= x_in;
      ph_r <= rel[1:0];
    end
    if (lo_cyc) begin
      plo_r <= prod;
    end
    if (hi_cyc) begin
      s_r <= prod + (plo_r >>> 24);
    end
    if (act_r && fin_cyc) begin
      acc_r <= sum;
      if (j == 3'd0) begin
        y_r <= sat48(sum);
      end
    end
  end

  // Slot activity and delay state
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      act_r <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
        d1_r[p] <= '0;
        d2_r[p] <= '0;
      end
    end else begin
      if (ctrl.cyc == 4'd0) begin
        act_r <= ctrl.run && active;
      end
      if (act_r && fin_cyc && (j == 3'd2)) begin
        d1_r[ph_r] <= sat48(sum);
      end
      if (act_r && fin_cyc && (j == 3'd4)) begin
        d2_r[ph_r] <= sat48(sum);
      end
    end
  end

  assign y_out = y_r;

`ifndef NO_ASSERTIONS
  // y is final before the next cell samples it at slot start
  a_y_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && (ctrl.cyc == 4'd0)) |-> $stable(y_r))
    else $error("cell output changed at slot boundary");
  // phase-0 delays never change while the cell is outside a slot
  a_d_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!act_r && !ctrl.clr) |=> ($stable(d1_r[0]) && $stable(d2_r[0])))
    else $error("idle cell changed its delays");
  // phase index stays in range while active
  a_ph_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (ph_r != 2'd3))
    else $error("cell phase index out of range");
`endif

endmodule

[src/three_phase_elliptic_lowpass.sv]
// Channel   Dir  Ports                      Content
// in_       in   tvalid/tready/tdata/tuser  tdata: u, v, w samples; tuser: opcode
// out_      out  tvalid/tready/tdata        tdata: u, v, w filtered results
//
// A step runs (PHASES + STAGES - 1) slots and then loads the output register in ST_HOLD;
// out_tvalid rises as the block returns to ST_IDLE, where the next input can be taken.
// A prime is the run alone, with no output load.
// Clear and the unused opcode finish in the cycle they are accepted.
// Synchronous active-low reset zeroes all delays. Input is taken while a result
// waits; the next finished step stalls the block until out_tready frees the output.
module three_phase_elliptic_lowpass
  import tpel_pkg::*;
#(
  parameter int STAGES      = STAGES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // phase_u_sample, phase_v_sample, phase_w_sample
  input  logic [((PHASES*SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,
  // opcode
  input  logic [1:0]                                    in_tuser,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // phase_u_filtered, phase_v_filtered, phase_w_filtered
  output logic [((PHASES*SAMPLE_BITS+7)/8)*8-1:0]       out_tdata
);

  localparam int DATA_W    = ((PHASES*SAMPLE_BITS+7)/8)*8;
  localparam int DF        = 40 - SAMPLE_BITS;
  localparam int LAST_SLOT = PHASES + STAGES - 2;

  state_t                  state_r, state_nxt;
  logic [CYC_W-1:0]        cyc_r, cyc_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic                    prime_r, prime_nxt;
  logic [SAMPLE_BITS-1:0]  smp_r [PHASES];
  logic [SAMPLE_BITS-1:0]  res_r [PHASES];
  logic [DATA_W-1:0]       res_cat;
  logic [DATA_W-1:0]       out_tdata_r;
  logic                    out_tvalid_r;

  logic in_xfer;
  logic slot_end;
  logic load_out;
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_end  = (cyc_r == 4'(SLOT_CYC - 1));
  assign load_out  = (state_r == ST_HOLD) && (!out_tvalid_r || out_tready);

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    cyc_nxt   = cyc_r;
    slot_nxt  = slot_r;
    prime_nxt = prime_r;
    case (state_r)
      ST_IDLE: begin
        cyc_nxt  = '0;
        slot_nxt = '0;
        if (in_xfer && ((in_tuser == OP_STEP) || (in_tuser == OP_PRIME))) begin
          state_nxt = ST_RUN;
          prime_nxt = (in_tuser == OP_PRIME);
        end
      end
      ST_RUN: begin
        if (slot_end) begin
          cyc_nxt = '0;
          if (slot_r == SLOT_W'(LAST_SLOT)) begin
            slot_nxt  = '0;
            state_nxt = prime_r ? ST_IDLE : ST_HOLD;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end else begin
          cyc_nxt = cyc_r + 1'b1;
        end
      end
      ST_HOLD: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cyc_r   <= '0;
      slot_r  <= '0;
      prime_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cyc_r   <= cyc_nxt;
      slot_r  <= slot_nxt;
      prime_r <= prime_nxt;
    end
  end

  // Sample capture on accepted transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int p = 0; p < PHASES; p++) begin
        smp_r[p] <= in_tdata[p*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
  end

  ctrl_t ctrl;
  assign ctrl.run   = (state_r == ST_RUN);
  assign ctrl.prime = prime_r;
  assign ctrl.clr   = in_xfer && (in_tuser == OP_CLEAR);
  assign ctrl.cyc   = cyc_r;
  assign ctrl.slot  = slot_r;

  // Chain head: sample of the phase entering in this slot, scaled to delay format
  logic signed [DLY_W-1:0] link [STAGES+1];
  logic [SAMPLE_BITS-1:0]  head_smp;
  always_comb begin
    head_smp = '0;
    for (int p = 0; p < PHASES; p++) begin
      if (slot_r == SLOT_W'(p)) begin
        head_smp = smp_r[p];
      end
    end
  end
  assign link[0] = {{(DLY_W-SAMPLE_BITS-DF){head_smp[SAMPLE_BITS-1]}}, head_smp, {DF{1'b0}}};

  for (genvar s = 0; s < STAGES; s++) begin : g_cell
    tpel_cell #(
      .IDX(s)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctrl (ctrl),
      .x_in (link[s]),
      .y_out(link[s+1])
    );
  end

  // Output rounding and saturation
  logic signed [DLY_W:0]        yr;
  logic signed [DLY_W:0]        yv;
  logic signed [DLY_W:0]        ymax;
  logic [SAMPLE_BITS-1:0]       yq;
  always_comb begin
    yr   = {link[STAGES][DLY_W-1], link[STAGES]} + ((DLY_W+1)'(1) <<< (DF - 1));
    yv   = yr >>> DF;
    ymax = (DLY_W+1)'((1 << (SAMPLE_BITS - 1)) - 1);
    if (yv > ymax) begin
      yq = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (yv < ~ymax) begin
      yq = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      yq = yv[SAMPLE_BITS-1:0];
    end
  end

  // Collect each phase as it leaves the last cell
  logic [SLOT_W-1:0] out_ph;
  assign out_ph = slot_r - SLOT_W'(STAGES - 1);
  always_ff @(posedge clk) begin
    if ((state_r == ST_RUN) && slot_end && (slot_r >= SLOT_W'(STAGES - 1))) begin
      for (int p = 0; p < PHASES; p++) begin
        if (out_ph == SLOT_W'(p)) begin
          res_r[p] <= yq;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // Pack the phase results, zero-filled to whole bytes
  always_comb begin
    res_cat = '0;
    for (int p = 0; p < PHASES; p++) begin
      res_cat[p*SAMPLE_BITS +: SAMPLE_BITS] = res_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= res_cat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input taken while busy");
  a_cyc_range: assert property (@(posedge clk) disable iff (!rst_n)
    cyc_r <= 4'(SLOT_CYC - 1))
    else $error("slot cycle counter out of range");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_tuser == OP_STEP)) |=> ((state_r == ST_RUN) && (cyc_r == '0)
      && (slot_r == '0)))
    else $error("step did not start the sequencer");
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && slot_end && (slot_r == SLOT_W'(LAST_SLOT)))
      |=> (state_r != ST_RUN))
    else $error("sequencer ran past the last slot");
`endif

endmodule
